/* design/scba_pkg.sv */
// Shared types, codes and constants for the size-class block allocator.
`default_nettype none

package scba_pkg;

	localparam int NUM_BUCKETS_DEF = 160;
	localparam int FREE_DEPTH_DEF  = 64;

	localparam int SIZE_W   = 64;
	localparam int OFFSET_W = 64;
	localparam int STACK_W  = 56;
	localparam int GRANT_W  = 50;
	localparam int BUCKET_W = 8;
	localparam int STATUS_W = 3;

	localparam logic [SIZE_W-1:0] SMALL_LIMIT   = 64'd1024;
	localparam logic [5:0]        BUCKET0_SHIFT = 6'd10;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} command_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK           = 3'd0,
		STS_TOO_LARGE    = 3'd1,
		STS_NO_SPACE     = 3'd2,
		STS_FREE_IGNORED = 3'd3,
		STS_STACK_FULL   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENC,
		ST_CLS,
		ST_LOOK,
		ST_EXEC,
		ST_POP,
		ST_OUT
	} state_t;

	// Stage enables for the size decoder
	typedef struct packed {
		logic load;
		logic step;
	} dec_ctl_t;

endpackage

`default_nettype wire

/* design/scba_size_decode.sv */
// Two-stage size-to-bucket decoder: size minus one, then leading-one search; class extraction is combinational.
`default_nettype none

module scba_size_decode (
	input  wire                               clk,
	input  wire  scba_pkg::dec_ctl_t          ctl,
	input  wire  [scba_pkg::SIZE_W-1:0]       request_size,
	output logic [scba_pkg::BUCKET_W-1:0]     bucket
);
	import scba_pkg::*;

	logic [SIZE_W-1:0] m_s1;
	logic              small_s1;
	logic [SIZE_W-1:0] m_s2;
	logic              small_s2;
	logic [5:0]        top_s2;

	logic [5:0]        oct;
	logic [SIZE_W-1:0] sel;

	function automatic logic [5:0] top_bit(input logic [SIZE_W-1:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < SIZE_W; i++) begin
			if (v[i]) begin
				p = 6'(i);
			end
		end
		return p;
	endfunction

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			m_s1     <= request_size - 64'd1;
			small_s1 <= (request_size <= SMALL_LIMIT);
		end
		if (ctl.step) begin
			m_s2     <= m_s1;
			small_s2 <= small_s1;
			top_s2   <= top_bit(m_s1);
		end
	end

	// Octave above 1024 and the two bits just below the leading one
	assign oct = top_s2 - BUCKET0_SHIFT;
	assign sel = m_s2 >> (7'(oct) + 7'd8);
	assign bucket = small_s2 ? '0 : ({oct, sel[1:0]} + 8'd1);

endmodule

`default_nettype wire

/* design/size_class_block_allocator_core.sv */
// Top level of the size-class block allocator: sequencer, bucket and stack memories.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-------------------------------------------
//   in      | in_valid  | in_stall  | command, request_size, handle
//   out     | out_valid | out_stall | status, block_handle, granted_size
//
// A transaction runs through ENC, CLS, LOOK, EXEC (then POP when a block comes off a
// free stack) and OUT before the next acceptance: one bucket-memory read-modify-write,
// plus a dependent stack-memory read on a pop; the leading-one search runs in ENC.
// Reset clears the control state, the bucket valid bits and the group bits at once;
// the stack memory is not cleared.
// A result waits in the output register; while it is held the sequencer holds in
// its final state and in_stall stays high.
`default_nettype none

module size_class_block_allocator_core #(
	parameter int NUM_BUCKETS = scba_pkg::NUM_BUCKETS_DEF,
	parameter int FREE_DEPTH  = scba_pkg::FREE_DEPTH_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire                               command,
	input  wire  [scba_pkg::SIZE_W-1:0]       request_size,
	input  wire  [scba_pkg::OFFSET_W-1:0]     handle,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic [scba_pkg::STATUS_W-1:0]     status,
	output logic [scba_pkg::OFFSET_W-1:0]     block_handle,
	output logic [scba_pkg::GRANT_W-1:0]      granted_size
);
	import scba_pkg::*;

	localparam int BW     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int CW     = $clog2(FREE_DEPTH + 1);
	localparam int SD     = NUM_BUCKETS * FREE_DEPTH;
	localparam int SAW    = (SD > 1) ? $clog2(SD) : 1;
	localparam int GROUPS = (NUM_BUCKETS + 7) / 8;
	localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int EW     = CW + OFFSET_W;

	state_t state_q, state_d;
	dec_ctl_t dec_ctl;
	logic out_load;

	// Captured transaction
	command_t              cmd_q;
	logic [OFFSET_W-1:0]   handle_q;
	logic [BUCKET_W-1:0]   dec_bucket;
	logic [BUCKET_W-1:0]   cls_bucket;
	logic                  cls_in_range;

	// Bucket lookup
	logic [BUCKET_W-1:0]   bucket_q;
	logic                  in_range_q;
	logic [EW-1:0]         bentry_q;
	logic                  bvalid_rd_q;
	logic [CW-1:0]         cnt_q;
	logic [OFFSET_W-1:0]   end_q;
	logic [OFFSET_W-1:0]   csize_q;
	logic [SAW-1:0]        base_q;
	logic                  grp_hit_q;
	logic [4:0]            gidx;

	// Memories and per-entry flags
	logic [EW-1:0]         bmem [NUM_BUCKETS];
	logic [NUM_BUCKETS-1:0] bvalid_q;
	logic [GROUPS-1:0]     grp_q;
	logic [STACK_W-1:0]    smem [SD];
	logic [STACK_W-1:0]    smem_rd_q;

	// Execute decisions
	logic                  is_alloc;
	logic [OFFSET_W:0]     sum;
	logic                  do_pop, do_bump, do_push, stack_full;
	logic                  bmem_we;
	logic [CW-1:0]         bmem_wcnt;
	logic [OFFSET_W-1:0]   bmem_wend;
	logic [SAW-1:0]        push_addr, pop_addr;

	// Result staging and output register
	status_t               res_status_q;
	logic [OFFSET_W-1:0]   res_handle_q;
	logic [GRANT_W-1:0]    res_size_q;
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [OFFSET_W-1:0]   out_handle_q;
	logic [GRANT_W-1:0]    out_size_q;

	scba_size_decode u_decode (
		.clk          (clk),
		.ctl          (dec_ctl),
		.request_size (request_size),
		.bucket       (dec_bucket)
	);

	assign cls_bucket   = (cmd_q == CMD_FREE) ? handle_q[BUCKET_W-1:0] : dec_bucket;
	assign cls_in_range = (cls_bucket < BUCKET_W'(NUM_BUCKETS));
	assign gidx         = bucket_q[BUCKET_W-1:3];

	assign is_alloc   = (cmd_q == CMD_ALLOC);
	assign sum        = {1'b0, end_q} + {1'b0, csize_q};
	assign stack_full = (cnt_q >= CW'(FREE_DEPTH));
	assign do_pop     = is_alloc && in_range_q && (cnt_q != '0);
	assign do_bump    = is_alloc && in_range_q && (cnt_q == '0) && !sum[OFFSET_W];
	assign do_push    = !is_alloc && grp_hit_q && !stack_full;
	assign bmem_we    = (state_q == ST_EXEC) && (do_pop || do_bump || do_push);
	assign bmem_wcnt  = do_pop ? (cnt_q - CW'(1)) : (do_push ? (cnt_q + CW'(1)) : cnt_q);
	assign bmem_wend  = do_bump ? sum[OFFSET_W-1:0] : end_q;
	assign push_addr  = base_q + SAW'(cnt_q);
	assign pop_addr   = base_q + SAW'(cnt_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_stall     = 1'b1;
		dec_ctl.load = 1'b0;
		dec_ctl.step = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall     = 1'b0;
				dec_ctl.load = in_valid;
				if (in_valid) begin
					state_d = ST_ENC;
				end
			end
			ST_ENC: begin
				dec_ctl.step = 1'b1;
				state_d      = ST_CLS;
			end
			ST_CLS: begin
				state_d = ST_LOOK;
			end
			ST_LOOK: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = do_pop ? ST_POP : ST_OUT;
			end
			ST_POP: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// Hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q    <= command_t'(command);
			handle_q <= handle;
		end
		if (state_q == ST_CLS) begin
			bucket_q   <= cls_bucket;
			in_range_q <= cls_in_range;
			if (cls_in_range) begin
				bentry_q    <= bmem[cls_bucket[BW-1:0]];
				bvalid_rd_q <= bvalid_q[cls_bucket[BW-1:0]];
			end else begin
				bvalid_rd_q <= 1'b0;
			end
		end
		if (state_q == ST_LOOK) begin
			// An entry never written reads as an empty bucket at offset zero
			cnt_q     <= bvalid_rd_q ? bentry_q[EW-1:OFFSET_W] : '0;
			end_q     <= bvalid_rd_q ? bentry_q[OFFSET_W-1:0] : '0;
			csize_q   <= OFFSET_W'({1'b1, bucket_q[1:0], 8'b0}) << bucket_q[BUCKET_W-1:2];
			base_q    <= SAW'(bucket_q[BW-1:0]) * SAW'(FREE_DEPTH);
			grp_hit_q <= in_range_q ? grp_q[gidx[GW-1:0]] : 1'b0;
		end
		if (bmem_we) begin
			bmem[bucket_q[BW-1:0]] <= {bmem_wcnt, bmem_wend};
		end
		if (state_q == ST_EXEC && do_push) begin
			smem[push_addr] <= handle_q[OFFSET_W-1:8];
		end
		if (state_q == ST_EXEC && do_pop) begin
			smem_rd_q <= smem[pop_addr];
		end
		if (state_q == ST_EXEC) begin
			res_status_q <= STS_OK;
			res_handle_q <= '0;
			res_size_q   <= '0;
			if (is_alloc) begin
				if (!in_range_q) begin
					res_status_q <= STS_TOO_LARGE;
					res_handle_q <= '1;
				end else if (cnt_q == '0 && sum[OFFSET_W]) begin
					res_status_q <= STS_NO_SPACE;
					res_handle_q <= '1;
				end else begin
					res_handle_q <= end_q | OFFSET_W'(bucket_q);
					res_size_q   <= csize_q[GRANT_W-1:0];
				end
			end else if (!grp_hit_q) begin
				res_status_q <= STS_FREE_IGNORED;
			end else if (stack_full) begin
				res_status_q <= STS_STACK_FULL;
			end
		end
		if (state_q == ST_POP) begin
			res_status_q <= STS_OK;
			res_handle_q <= {smem_rd_q, bucket_q};
			res_size_q   <= csize_q[GRANT_W-1:0];
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_handle_q <= res_handle_q;
			out_size_q   <= res_size_q;
		end
	end

	// Control flags: bucket valid bits, group bits, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q    <= '0;
			grp_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (bmem_we) begin
				bvalid_q[bucket_q[BW-1:0]] <= 1'b1;
			end
			// Any in-range allocate creates the group, even when it runs out of space
			if (state_q == ST_EXEC && is_alloc && in_range_q) begin
				grp_q[gidx[GW-1:0]] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign block_handle = out_handle_q;
	assign granted_size = out_size_q;

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("output valid rose without a result from the sequencer");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> $past(state_q == ST_EXEC && cnt_q != '0))
		else $error("pop from an empty free stack");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bmem_we |-> (bmem_wcnt <= CW'(FREE_DEPTH)))
		else $error("free stack count written beyond depth");

	a_too_large: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STS_TOO_LARGE) |-> (block_handle == '1 && granted_size == '0))
		else $error("oversize allocate returned a handle or size");

endmodule

`default_nettype wire

/* dv/tb_size_class_block_allocator_core.sv */
// Testbench for size_class_block_allocator_core: queued stimulus, in-line allocator model, checker.
`timescale 1ns / 100ps

module tb_size_class_block_allocator_core;
	import scba_pkg::*;

	localparam int NB = NUM_BUCKETS_DEF;
	localparam int FD = FREE_DEPTH_DEF;
	localparam int NG = (NB + 7) / 8;
	localparam int RAND_ITEMS = 1350;
	localparam int HOLD_CYCLES = 400;
	localparam int GAP_MAX = 40;
	localparam int STALL_MAX = 40;
	localparam int TAIL_CYCLES = 30;

	typedef struct {
		command_t          cmd;
		logic [63:0]       size;
		logic [63:0]       hdl;
		int                gap;
		bit                sync;
	} request_t;

	typedef struct {
		status_t           sts;
		logic [63:0]       hdl;
		logic [GRANT_W-1:0] gsz;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = CMD_ALLOC;
	logic [SIZE_W-1:0] request_size = '0;
	logic [OFFSET_W-1:0] handle = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [OFFSET_W-1:0] block_handle;
	logic [GRANT_W-1:0] granted_size;

	// allocator state as seen by the model
	logic [STACK_W-1:0] stack_mem [NB*FD];
	int unsigned stack_fill [NB];
	logic [63:0] bump_off [NB];
	bit group_live [NG];

	request_t requests_pending [$];
	reply_t replies_due [$];
	request_t cur;
	bit have_cur = 1'b0;
	int gap_left = 0;
	int n_accepted = 0;
	int n_res_seen = 0;
	int n_bad = 0;
	int stall_left = 0;
	bit calm = 1'b0;
	logic long_hold = 1'b0;
	longint cycles = 0;
	longint cycle_limit = 64'd100_000_000;

	size_class_block_allocator_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.request_size (request_size),
		.handle       (handle),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.block_handle (block_handle),
		.granted_size (granted_size)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] class_bytes(int b);
		logic [63:0] base;
		base = 64'd1024 | (64'(b & 3) << 8);
		return base << (b >> 2);
	endfunction

	function automatic int size_bucket(logic [63:0] sz);
		logic [63:0] m;
		int top;
		int a;
		if (sz <= SMALL_LIMIT)
			return 0;
		m = sz - 64'd1;
		top = 0;
		for (int i = 0; i < 64; i++)
			if (m[i])
				top = i;
		a = top - 10;
		return ((a << 2) | int'((m >> (a + 8)) & 64'd3)) + 1;
	endfunction

	// Apply one request to the model state and return the reply it produces.
	function automatic reply_t serve_request(request_t r);
		reply_t o;
		int b;
		logic [63:0] cls;
		logic [63:0] addr;
		o.sts = STS_OK;
		o.hdl = '0;
		o.gsz = '0;
		if (r.cmd == CMD_ALLOC) begin
			b = size_bucket(r.size);
			if (b >= NB) begin
				o.sts = STS_TOO_LARGE;
				o.hdl = '1;
				return o;
			end
			cls = class_bytes(b);
			group_live[b >> 3] = 1'b1;
			if (stack_fill[b] > 0) begin
				stack_fill[b]--;
				addr = {stack_mem[b*FD + stack_fill[b]], 8'h00};
			end else if (bump_off[b] > ~64'd0 - cls) begin
				o.sts = STS_NO_SPACE;
				o.hdl = '1;
				return o;
			end else begin
				addr = bump_off[b];
				bump_off[b] = addr + cls;
			end
			o.hdl = addr | 64'(b);
			o.gsz = cls[GRANT_W-1:0];
		end else begin
			b = int'(r.hdl[7:0]);
			if (b >= NB || !group_live[b >> 3])
				o.sts = STS_FREE_IGNORED;
			else if (stack_fill[b] >= FD)
				o.sts = STS_STACK_FULL;
			else begin
				stack_mem[b*FD + stack_fill[b]] = r.hdl[63:8];
				stack_fill[b]++;
			end
		end
		return o;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic int pick_gap(bit quiet);
		int p;
		if (quiet)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 65)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		if (p < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, GAP_MAX);
	endfunction

	// Random size that rounds to bucket b; optionally pick a class boundary.
	function automatic logic [63:0] size_for(int b, bit at_bound);
		logic [63:0] lo;
		logic [63:0] hi;
		lo = (b == 0) ? 64'd0 : class_bytes(b - 1) + 64'd1;
		hi = class_bytes(b);
		if (at_bound)
			return $urandom_range(0, 1) ? lo : hi;
		return lo + rand64() % (hi - lo + 64'd1);
	endfunction

	function automatic logic [63:0] handle_in(int b);
		return (rand64() & ~64'hFF) | 64'(b & 8'hFF);
	endfunction

	task automatic post(command_t c, logic [63:0] sz, logic [63:0] h, int gap, bit sync);
		request_t r;
		r.cmd = c;
		r.size = sz;
		r.hdl = h;
		r.gap = gap;
		r.sync = sync;
		requests_pending.insert(requests_pending.size(), r);
	endtask

	// Driver: hold a transaction until accepted, then load the next one.
	always @(posedge clk or negedge arst_n) begin : driver
		logic v_next;
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= CMD_ALLOC;
			request_size <= '0;
			handle <= '0;
		end else begin
			v_next = in_valid;
			if (in_valid && !in_stall) begin
				replies_due.insert(replies_due.size(), serve_request(cur));
				n_accepted++;
				have_cur = 1'b0;
				v_next = 1'b0;
			end
			if (!have_cur && requests_pending.size() != 0 &&
			    (!requests_pending[0].sync || n_accepted == n_res_seen)) begin
				cur = requests_pending.pop_front();
				have_cur = 1'b1;
				gap_left = cur.gap;
			end
			if (have_cur && !v_next) begin
				if (gap_left > 0)
					gap_left--;
				else begin
					v_next = 1'b1;
					command <= cur.cmd;
					request_size <= cur.size;
					handle <= cur.hdl;
				end
			end
			in_valid <= v_next;
		end
	end

	// Monitor: check each result against the oldest pending reply, then pick the next stall.
	always @(posedge clk or negedge arst_n) begin : monitor
		reply_t want;
		logic stall_next;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("unexpected result: status %0d handle %h size %h",
							status, block_handle, granted_size);
				end else begin
					want = replies_due.pop_front();
					if (status !== want.sts || block_handle !== want.hdl ||
					    granted_size !== want.gsz) begin
						n_bad++;
						if (n_bad <= 10)
							$display("mismatch: status %0d exp %0d, handle %h exp %h, size %h exp %h",
								status, want.sts, block_handle, want.hdl,
								granted_size, want.gsz);
					end
				end
				n_res_seen <= n_res_seen + 1;
			end
			if (stall_left > 0) begin
				stall_left--;
				stall_next = 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_next = 1'b1;
				stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(8, STALL_MAX) :
					$urandom_range(0, 2);
			end else
				stall_next = 1'b0;
			out_stall <= stall_next | long_hold;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles[8:0] == 0)
			calm <= ($urandom_range(0, 3) == 0);
		if (cycles > cycle_limit) begin
			$display("[size_class_block_allocator_core] ERROR");
			$finish;
		end
	end

	// Block the output for a long stretch so the input side backs up.
	initial begin
		wait (n_accepted >= 300);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		int kind;
		int len;
		int n_hot;
		int n_rand;
		int free_pct;
		int p;
		int q;
		int b;
		int hot [4];
		bit quiet;
		logic [63:0] sz;
		logic [63:0] h;

		for (int i = 0; i < NB; i++) begin
			stack_fill[i] = 0;
			bump_off[i] = '0;
		end
		for (int i = 0; i < NG; i++)
			group_live[i] = 1'b0;

		// directed: edges of the size range, bad buckets, absent groups, LIFO reuse
		post(CMD_FREE, rand64(), handle_in(0), 0, 1'b1);
		post(CMD_FREE, rand64(), handle_in(8'hFF), pick_gap(0), 1'b0);
		post(CMD_FREE, rand64(), handle_in(NB), pick_gap(0), 1'b0);
		post(CMD_ALLOC, 64'd0, rand64(), pick_gap(0), 1'b0);
		post(CMD_ALLOC, 64'd1024, rand64(), pick_gap(0), 1'b0);
		post(CMD_ALLOC, 64'd1025, rand64(), pick_gap(0), 1'b0);
		post(CMD_ALLOC, 64'd1280, rand64(), pick_gap(0), 1'b0);
		post(CMD_ALLOC, 64'd1281, rand64(), pick_gap(0), 1'b0);
		post(CMD_ALLOC, '1, rand64(), pick_gap(0), 1'b0);
		post(CMD_ALLOC, class_bytes(NB - 1), rand64(), pick_gap(0), 1'b0);
		post(CMD_ALLOC, class_bytes(NB - 1) + 64'd1, rand64(), pick_gap(0), 1'b0);
		post(CMD_FREE, rand64(), 64'hFFFF_FFFF_FFFF_FF00, pick_gap(0), 1'b0);
		post(CMD_ALLOC, 64'd1, rand64(), pick_gap(0), 1'b0);
		post(CMD_FREE, rand64(), handle_in(8), pick_gap(0), 1'b0);
		post(CMD_FREE, rand64(), handle_in(7), pick_gap(0), 1'b0);
		post(CMD_ALLOC, size_for(7, 1'b0), rand64(), pick_gap(0), 1'b0);
		post(CMD_FREE, rand64(), 64'h5555_5555_5555_5500 | 64'(NB - 1), pick_gap(0), 1'b0);
		post(CMD_FREE, rand64(), 64'hAAAA_AAAA_AAAA_AA00 | 64'(NB - 1), pick_gap(0), 1'b0);
		post(CMD_ALLOC, class_bytes(NB - 1), rand64(), pick_gap(0), 1'b0);
		post(CMD_ALLOC, class_bytes(NB - 2) + 64'd1, rand64(), pick_gap(0), 1'b0);
		post(CMD_ALLOC, 64'h8000_0000_0000_0000, rand64(), pick_gap(0), 1'b0);

		// random segments: mixed, free-heavy, alloc-heavy and noise over a few hot buckets
		n_rand = 0;
		while (n_rand < RAND_ITEMS) begin
			kind = $urandom_range(0, 3);
			len = $urandom_range(80, 220);
			quiet = ($urandom_range(0, 4) == 0);
			n_hot = $urandom_range(1, 4);
			for (int k = 0; k < n_hot; k++)
				hot[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NB - 1) :
					$urandom_range(0, 15);
			free_pct = (kind == 1) ? 70 : (kind == 2) ? 25 : 45;
			for (int j = 0; j < len; j++) begin
				p = $urandom_range(0, 99);
				q = $urandom_range(0, 19);
				b = hot[$urandom_range(0, n_hot - 1)];
				if (kind == 3 && p < 60)
					post(command_t'($urandom_range(0, 1)), rand64(), rand64(),
						pick_gap(quiet), j == 0);
				else if (p < free_pct) begin
					h = (q < 16) ? handle_in(b) : handle_in($urandom_range(0, 255));
					post(CMD_FREE, rand64(), h, pick_gap(quiet), j == 0);
				end else begin
					if (q < 14)
						sz = size_for(b, $urandom_range(0, 3) == 0);
					else if (q < 16)
						sz = size_for($urandom_range(0, NB - 1), $urandom_range(0, 1));
					else if (q < 18)
						sz = $urandom_range(0, 1024);
					else if (q == 18)
						sz = rand64();
					else
						sz = class_bytes(NB - 1) + 64'd1;
					post(CMD_ALLOC, sz, rand64(), pick_gap(quiet), j == 0);
				end
			end
			n_rand += len;
		end

		// overfill the largest class's free stack, then pop everything back
		for (int j = 0; j < FD + 2; j++)
			post(CMD_FREE, rand64(), handle_in(NB - 1), pick_gap(0), j == 0);
		for (int j = 0; j < FD + 2; j++)
			post(CMD_ALLOC, class_bytes(NB - 1), rand64(), pick_gap(0), 1'b0);

		cycle_limit = longint'(requests_pending.size()) * (7 + GAP_MAX + STALL_MAX + 4) * 4 +
			HOLD_CYCLES + 50000;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		@(negedge clk);
		while (requests_pending.size() != 0 || have_cur || n_res_seen != n_accepted)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (n_bad == 0 && replies_due.size() == 0)
			$display("[size_class_block_allocator_core] OK");
		else
			$display("[size_class_block_allocator_core] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
design/scba_pkg.sv
design/scba_size_decode.sv
design/size_class_block_allocator_core.sv
dv/tb_size_class_block_allocator_core.sv
